/* hw/rtl/vagd_pkg.sv */
package vagd_pkg;

    typedef enum logic {
        OP_END,
        OP_DATA
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [2:0] filter;
        logic [3:0] shift;
    } req_t;

    localparam logic [3:0] FILTER_COUNT = 4'd5;
    localparam logic [7:0] END_FLAG     = 8'h07;
    localparam logic [3:0] POS_HEADER   = 4'd0;
    localparam logic [3:0] POS_FLAG     = 4'd1;
    localparam logic [3:0] POS_DATA     = 4'd2;

    // Prediction taps, integers over 64
    function automatic logic signed [7:0] coef_one(input logic [2:0] f);
        logic signed [7:0] c;
        case (f)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [7:0] coef_two(input logic [2:0] f);
        logic signed [7:0] c;
        case (f)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/vagd_front.sv */
module vagd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    output logic           push,
    output vagd_pkg::req_t push_req,
    input  logic           full
);
    import vagd_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic [2:0] filter_reg, filter_next;
    logic [3:0] shift_reg, shift_next;
    logic       accept;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next        = pos_reg;
        filter_next     = filter_reg;
        shift_next      = shift_reg;
        push            = 1'b0;
        push_req.op     = OP_DATA;
        push_req.data   = s_data_byte;
        push_req.filter = filter_reg;
        push_req.shift  = shift_reg;
        if (accept) begin
            case (pos_reg)
                POS_HEADER: begin
                    // unknown filter codes fall back to no prediction
                    filter_next = (s_data_byte[7:4] < FILTER_COUNT) ? s_data_byte[6:4] : 3'd0;
                    shift_next  = s_data_byte[3:0];
                    pos_next    = POS_FLAG;
                end
                POS_FLAG: begin
                    if (s_data_byte == END_FLAG) begin
                        push        = 1'b1;
                        push_req.op = OP_END;
                        pos_next    = POS_HEADER;
                    end else begin
                        pos_next = POS_DATA;
                    end
                end
                default: begin
                    push     = 1'b1;
                    pos_next = pos_reg + 4'd1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_HEADER;
            filter_reg <= 3'd0;
            shift_reg  <= 4'd0;
        end else begin
            pos_reg    <= pos_next;
            filter_reg <= filter_next;
            shift_reg  <= shift_next;
        end
    end

endmodule

/* hw/rtl/vagd_fifo.sv */
module vagd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vagd_pkg::req_t push_req,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output vagd_pkg::req_t head_req
);
    import vagd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    req_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/vagd_back.sv */
module vagd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  vagd_pkg::req_t     head_req,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_pcm_sample,
    output logic               m_stream_end,
    output logic               m_last_of_item
);
    import vagd_pkg::*;

    logic signed [31:0] hist1_reg, hist2_reg, hist_new;
    logic               half_reg;
    logic               m_valid_reg;
    logic signed [15:0] m_pcm_reg;
    logic               m_end_reg, m_last_reg;

    logic               step;
    logic [3:0]         nib;
    logic signed [15:0] raw;
    logic signed [39:0] prod1, prod2;
    logic signed [40:0] pred_sum, pred_q;
    logic signed [41:0] v;
    logic signed [33:0] t, t_adj;

    assign step = head_valid && (!m_valid_reg || m_ready);
    assign pop  = step && ((head_req.op == OP_END) || half_reg);

    always_comb begin
        nib      = half_reg ? head_req.data[7:4] : head_req.data[3:0];
        raw      = $signed({nib, 12'h000}) >>> head_req.shift;
        prod1    = 40'(hist1_reg) * 40'(coef_one(head_req.filter));
        prod2    = 40'(hist2_reg) * 40'(coef_two(head_req.filter));
        pred_sum = 41'(prod1) + 41'(prod2);
        // floor back to 6 fractional bits
        pred_q   = pred_sum >>> 6;
        v        = 42'(pred_q) + (42'(raw) <<< 6);
        if (v > 42'sd2147483647) begin
            hist_new = 32'sh7FFF_FFFF;
        end else if (v < -42'sd2147483648) begin
            hist_new = 32'sh8000_0000;
        end else begin
            hist_new = v[31:0];
        end
        // add one half, then divide by 64 truncating toward zero
        t     = 34'(hist_new) + 34'sd32;
        t_adj = t[33] ? t + 34'sd63 : t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist1_reg   <= '0;
            hist2_reg   <= '0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
            if (head_req.op == OP_END) begin
                hist1_reg <= '0;
                hist2_reg <= '0;
                half_reg  <= 1'b0;
            end else begin
                hist2_reg <= hist1_reg;
                hist1_reg <= hist_new;
                half_reg  <= !half_reg;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            if (head_req.op == OP_END) begin
                m_pcm_reg  <= '0;
                m_end_reg  <= 1'b1;
                m_last_reg <= 1'b1;
            end else begin
                m_pcm_reg  <= t_adj[21:6];
                m_end_reg  <= 1'b0;
                m_last_reg <= half_reg;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pcm_sample   = m_pcm_reg;
    assign m_stream_end   = m_end_reg;
    assign m_last_of_item = m_last_reg;

endmodule

/* hw/rtl/vag_adpcm_decoder.sv */
// VAG ADPCM decoder.
// Input: s_valid/s_ready/s_data_byte carries the frame stream one byte per request,
// 16-byte frames, file header already stripped. Byte 0 of a frame picks filter and
// shift, byte 1 is the flag byte, bytes 2..15 each decode into two samples.
// Output: m_valid/m_ready with m_pcm_sample, m_stream_end, m_last_of_item.
// A flag byte of 7 yields one end marker (sample 0) and clears position and history.
// Header bytes and other flag bytes are accepted and yield nothing.
// A data byte is queued, then each of its two samples is registered in the output
// register, first before second. The back end handles one nibble per cycle while the
// queue is not empty and the output register is free or being taken, because the
// single prediction multiply-add needs the history left by the previous sample.
// A queue of QUEUE_DEPTH requests sits between the byte parser and the decoder, so
// input keeps flowing while a finished sample waits in the output register.
// When the receiver stalls, the sample is held, the queue fills and s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and output register and
// clears position, filter, shift and history.
module vag_adpcm_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_pcm_sample,
    output logic               m_stream_end,
    output logic               m_last_of_item
);
    import vagd_pkg::*;

    logic push, full, pop, head_valid;
    req_t push_req, head_req;

    vagd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push        (push),
        .push_req    (push_req),
        .full        (full)
    );

    vagd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    vagd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_req       (head_req),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pcm_sample   (m_pcm_sample),
        .m_stream_end   (m_stream_end),
        .m_last_of_item (m_last_of_item)
    );

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> (m_pcm_sample == 16'sd0) && m_last_of_item)
        else $error("end marker with sample or without last flag");

    a_second_half: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_item |=> m_valid)
        else $error("second sample of a byte did not follow");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule
